[src/aff2d_pkg.sv]
// Package for the 2D affine concatenate/invert block.
// Holds payload beat types, controller state and command/status structs.
`timescale 1ns / 1ps
package aff2d_pkg;

    localparam int unsigned FIELD_BITS = 32;

    typedef struct packed {
        logic                         func;
        logic signed [FIELD_BITS-1:0] in_a;
        logic signed [FIELD_BITS-1:0] in_b;
        logic signed [FIELD_BITS-1:0] in_c;
        logic signed [FIELD_BITS-1:0] in_d;
        logic signed [FIELD_BITS-1:0] in_tx;
        logic signed [FIELD_BITS-1:0] in_ty;
    } aff2d_in_t;

    typedef struct packed {
        logic                         which;
        logic signed [FIELD_BITS-1:0] out_a;
        logic signed [FIELD_BITS-1:0] out_b;
        logic signed [FIELD_BITS-1:0] out_c;
        logic signed [FIELD_BITS-1:0] out_d;
        logic signed [FIELD_BITS-1:0] out_tx;
        logic signed [FIELD_BITS-1:0] out_ty;
        logic                         is_move;
        logic                         singular;
        logic                         saturated;
        logic                         last;
    } aff2d_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_FWD,
        ST_INV_PROD,
        ST_DET,
        ST_NUM,
        ST_DIV,
        ST_DIV_WAIT,
        ST_SEND_FWD,
        ST_SEND_INV
    } aff2d_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       prod;
        logic       fwd;
        logic       det;
        logic       num;
        logic       div_start;
        logic [2:0] div_idx;
        logic       show_fwd;
        logic       show_inv;
    } aff2d_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic prod_last;
        logic need_div;
        logic div_done;
    } aff2d_sts_t;

endpackage

[src/aff2d_ctrl.sv]
// Controller sequencing one item: products, forward sum, determinant, six
// divisions and the two result beats. Depends on aff2d_pkg.
`timescale 1ns / 1ps
module aff2d_ctrl
    import aff2d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_ready,
    output logic       out_valid,
    input  aff2d_sts_t sts,
    output aff2d_cmd_t cmd
);

    aff2d_state_t state_reg, state_next;
    logic [2:0]   idx_reg, idx_next;
    logic         ov_reg, ov_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_PROD;
            ST_PROD:     if (sts.prod_last) state_next = ST_FWD;
            ST_FWD:      state_next = ST_INV_PROD;
            ST_INV_PROD: if (sts.prod_last) state_next = ST_DET;
            ST_DET:      state_next = ST_SEND_FWD;
            ST_SEND_FWD:
                if (!ov_reg || out_ready)
                    state_next = sts.need_div ? ST_NUM : ST_SEND_INV;
            ST_NUM:
            begin
                state_next = ST_DIV;
                idx_next   = 3'd0;
            end
            ST_DIV:      state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (sts.div_done)
                begin
                    if (idx_reg == 3'd5)
                        state_next = ST_SEND_INV;
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_DIV;
                    end
                end
            ST_SEND_INV:
                if (!ov_reg || out_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Output valid flag
    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && out_ready) ov_next = 1'b0;
        if ((state_reg == ST_SEND_FWD || state_reg == ST_SEND_INV)
            && (!ov_reg || out_ready))
            ov_next = 1'b1;
    end

    // Commands
    always_comb
    begin
        cmd           = '0;
        cmd.div_idx   = idx_reg;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PROD:     cmd.prod = 1'b1;
            ST_FWD:      cmd.fwd = 1'b1;
            ST_INV_PROD: cmd.prod = 1'b1;
            ST_DET:      cmd.det = 1'b1;
            ST_NUM:      cmd.num = 1'b1;
            ST_DIV:      cmd.div_start = 1'b1;
            ST_SEND_FWD: cmd.show_fwd = (!ov_reg || out_ready);
            ST_SEND_INV: cmd.show_inv = (!ov_reg || out_ready);
            default:     in_ready = 1'b0;
        endcase
    end

    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

[src/aff2d_div.sv]
// Restoring signed divider, one quotient bit per cycle.
// Self-contained; used by the affine datapath.
`timescale 1ns / 1ps
module aff2d_div #(
    parameter int unsigned NB = 96
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NB-1:0] num,
    input  logic signed [NB-1:0] den,
    output logic                 done,
    output logic signed [NB-1:0] quo
);

    localparam int unsigned CW = $clog2(NB + 1);

    logic [NB-1:0] q_reg, q_next;
    logic [NB:0]   r_reg, r_next;
    logic [NB-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [NB:0]   trial;
    logic [NB:0]   shifted;

    // Iterate one bit
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {r_reg[NB-1:0], q_reg[NB-1]};
        trial     = shifted - {1'b0, d_reg};
        if (start)
        begin
            q_next    = num[NB-1] ? NB'(-num) : num;
            d_next    = den[NB-1] ? NB'(-den) : den;
            neg_next  = num[NB-1] ^ den[NB-1];
            r_next    = '0;
            cnt_next  = CW'(NB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[NB])
            begin
                r_next = trial;
                q_next = {q_reg[NB-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quo  = neg_reg ? NB'(-q_next) : q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

endmodule

[src/aff2d_dp.sv]
// Datapath: matrix state, one shared multiplier stepped over products,
// forward sums, determinant and the divider. Depends on aff2d_pkg, aff2d_div.
`timescale 1ns / 1ps
module aff2d_dp
    import aff2d_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned WORD_BITS = 32
)(
    input  logic       clk,
    input  logic       rst_n,
    input  aff2d_in_t  in_beat,
    input  aff2d_cmd_t cmd,
    output aff2d_sts_t sts,
    output aff2d_out_t out_beat
);

    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned IW = (W > FIELD_BITS) ? W : FIELD_BITS;
    localparam int unsigned PW = W + IW;
    localparam int unsigned SW = PW + 2;
    localparam int unsigned NB = PW + FRAC_BITS + 3;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    // One saturates when the fraction leaves no room for it
    localparam logic signed [W-1:0] ONE = (FRAC_BITS + 1 >= W) ? WMAX
                                                               : W'(1) <<< FRAC_BITS;

    logic signed [W-1:0]  m_reg [6];
    logic signed [IW-1:0] g_reg [6];
    logic signed [W-1:0]  f_reg [6];
    logic signed [W-1:0]  v_reg [6];
    logic signed [PW-1:0] p_reg [12];
    logic [3:0]           pi_reg;
    logic                 cf_reg, ci_reg, mv_reg, sg_reg;
    logic signed [SW-1:0] det_reg;
    logic signed [NB-1:0] num_reg [6];
    logic                 ph_reg;
    logic signed [W-1:0]  ma;
    logic signed [IW-1:0] mb;
    logic signed [PW-1:0] prod;
    logic signed [NB-1:0] quo;
    logic                 div_done;
    logic signed [W-1:0]  fw   [6];
    logic                 fclp [6];

    // Saturate a wide sum to the word
    function automatic logic signed [W-1:0] sat_w(input logic signed [NB-1:0] x,
                                                  output logic clip);
        logic signed [NB-1:0] hi, lo;
        begin
            hi   = NB'(WMAX);
            lo   = NB'(WMIN);
            clip = 1'b0;
            if (x > hi)
            begin
                clip  = 1'b1;
                sat_w = WMAX;
            end
            else if (x < lo)
            begin
                clip  = 1'b1;
                sat_w = WMIN;
            end
            else
                sat_w = x[W-1:0];
        end
    endfunction

    // Select multiplier operands per step
    always_comb
    begin
        ma = '0;
        mb = '0;
        if (ph_reg)
        begin
            case (pi_reg)
                4'd0: begin ma = f_reg[0]; mb = IW'(f_reg[3]); end
                4'd1: begin ma = f_reg[1]; mb = IW'(f_reg[2]); end
                4'd2: begin ma = f_reg[2]; mb = IW'(f_reg[5]); end
                4'd3: begin ma = f_reg[3]; mb = IW'(f_reg[4]); end
                4'd4: begin ma = f_reg[1]; mb = IW'(f_reg[4]); end
                4'd5: begin ma = f_reg[0]; mb = IW'(f_reg[5]); end
                default: begin ma = '0; mb = '0; end
            endcase
        end
        else
        begin
            // pi: bit0 picks a/b row vs c/d; index pairs per element of g
            ma = pi_reg[0] ? (pi_reg[1] ? m_reg[3] : m_reg[2])
                           : (pi_reg[1] ? m_reg[1] : m_reg[0]);
            mb = g_reg[3'(pi_reg[3:2]) * 3'd2 + 3'(pi_reg[0])];
        end
    end
    assign prod = ma * mb;

    assign sts.prod_last = ph_reg ? (pi_reg == 4'd5) : (pi_reg == 4'd11);
    assign sts.need_div  = !mv_reg && !sg_reg;
    assign sts.div_done  = div_done;

    aff2d_div #(.NB(NB)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg[cmd.div_idx]),
        .den   (NB'(det_reg)),
        .done  (div_done),
        .quo   (quo)
    );

    // Forward element k from stored products
    always_comb
    begin
        logic signed [NB-1:0] s;
        for (int k = 0; k < 6; k++)
        begin
            s = NB'(p_reg[2*k] >>> FRAC_BITS) + NB'(p_reg[2*k+1] >>> FRAC_BITS);
            if (k >= 4) s = s + NB'(m_reg[k]);
            fw[k] = sat_w(s, fclp[k]);
        end
    end

    // Matrix state and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg[0] <= ONE;
            m_reg[1] <= '0;
            m_reg[2] <= '0;
            m_reg[3] <= ONE;
            m_reg[4] <= '0;
            m_reg[5] <= '0;
            pi_reg   <= '0;
            ph_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                pi_reg <= '0;
                ph_reg <= 1'b0;
                if (in_beat.func)
                begin
                    m_reg[0] <= ONE;
                    m_reg[1] <= '0;
                    m_reg[2] <= '0;
                    m_reg[3] <= ONE;
                    m_reg[4] <= '0;
                    m_reg[5] <= '0;
                end
            end
            else if (cmd.prod)
                pi_reg <= pi_reg + 4'd1;
            else if (cmd.fwd)
            begin
                for (int k = 0; k < 6; k++) m_reg[k] <= fw[k];
                pi_reg <= '0;
                ph_reg <= 1'b1;
            end
        end
    end

    // Inverse elements and flags
    logic signed [W-1:0] qs;
    logic                qclp;
    logic signed [W-1:0] ntx, nty;
    logic                nxc, nyc;
    always_comb
    begin
        qs  = sat_w(quo, qclp);
        ntx = sat_w(-NB'(f_reg[4]), nxc);
        nty = sat_w(-NB'(f_reg[5]), nyc);
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            g_reg[0] <= IW'(in_beat.in_a);
            g_reg[1] <= IW'(in_beat.in_b);
            g_reg[2] <= IW'(in_beat.in_c);
            g_reg[3] <= IW'(in_beat.in_d);
            g_reg[4] <= IW'(in_beat.in_tx);
            g_reg[5] <= IW'(in_beat.in_ty);
        end
        if (cmd.prod)
            p_reg[pi_reg] <= prod;
        if (cmd.fwd)
        begin
            for (int k = 0; k < 6; k++) f_reg[k] <= fw[k];
            cf_reg <= fclp[0] | fclp[1] | fclp[2] | fclp[3] | fclp[4] | fclp[5];
            mv_reg <= (fw[0] == ONE) && (fw[1] == '0) && (fw[2] == '0)
                      && (fw[3] == ONE);
        end
        if (cmd.det)
        begin
            det_reg <= SW'((SW'(p_reg[0]) - SW'(p_reg[1])) >>> FRAC_BITS);
            sg_reg  <= !mv_reg &&
                       (SW'((SW'(p_reg[0]) - SW'(p_reg[1])) >>> FRAC_BITS) == '0);
            ci_reg  <= mv_reg ? (nxc | nyc) : 1'b0;
            v_reg[0] <= ONE;
            v_reg[1] <= '0;
            v_reg[2] <= '0;
            v_reg[3] <= ONE;
            v_reg[4] <= mv_reg ? ntx : '0;
            v_reg[5] <= mv_reg ? nty : '0;
        end
        if (cmd.num)
        begin
            num_reg[0] <= NB'(f_reg[3]) <<< FRAC_BITS;
            num_reg[1] <= -(NB'(f_reg[1]) <<< FRAC_BITS);
            num_reg[2] <= -(NB'(f_reg[2]) <<< FRAC_BITS);
            num_reg[3] <= NB'(f_reg[0]) <<< FRAC_BITS;
            num_reg[4] <= NB'(p_reg[2]) - NB'(p_reg[3]);
            num_reg[5] <= NB'(p_reg[4]) - NB'(p_reg[5]);
        end
        if (div_done)
        begin
            v_reg[cmd.div_idx] <= qs;
            ci_reg <= ci_reg | qclp;
        end
        if (cmd.show_fwd)
        begin
            out_beat.which     <= 1'b0;
            out_beat.out_a     <= FIELD_BITS'(f_reg[0]);
            out_beat.out_b     <= FIELD_BITS'(f_reg[1]);
            out_beat.out_c     <= FIELD_BITS'(f_reg[2]);
            out_beat.out_d     <= FIELD_BITS'(f_reg[3]);
            out_beat.out_tx    <= FIELD_BITS'(f_reg[4]);
            out_beat.out_ty    <= FIELD_BITS'(f_reg[5]);
            out_beat.is_move   <= mv_reg;
            out_beat.singular  <= 1'b0;
            out_beat.saturated <= cf_reg;
            out_beat.last      <= 1'b0;
        end
        if (cmd.show_inv)
        begin
            out_beat.which     <= 1'b1;
            out_beat.out_a     <= FIELD_BITS'(v_reg[0]);
            out_beat.out_b     <= FIELD_BITS'(v_reg[1]);
            out_beat.out_c     <= FIELD_BITS'(v_reg[2]);
            out_beat.out_d     <= FIELD_BITS'(v_reg[3]);
            out_beat.out_tx    <= FIELD_BITS'(v_reg[4]);
            out_beat.out_ty    <= FIELD_BITS'(v_reg[5]);
            out_beat.is_move   <= mv_reg;
            out_beat.singular  <= sg_reg;
            out_beat.saturated <= ci_reg;
            out_beat.last      <= 1'b1;
        end
    end

endmodule

[src/affine_2d_concat_and_inverse.sv]
// Affine 2x3 concatenate and invert, Q(FRAC_BITS) fixed point.
// Sequence: 12 forward products, 1 sum, 6 inverse products and 1 determinant,
// then the forward beat is offered. Six serial divisions of NB-bit words on
// the one divider follow (NB = WORD_BITS + max(WORD_BITS, 32) + FRAC_BITS + 3,
// 83 at defaults) before the inverse beat is offered; a pure move or a
// singular matrix skips the divisions.
// One item at a time. Reset loads identity and clears the output valid.
`timescale 1ns / 1ps
module affine_2d_concat_and_inverse
    import aff2d_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned WORD_BITS = 32
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  aff2d_in_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output aff2d_out_t out_data
);

    aff2d_cmd_t cmd;
    aff2d_sts_t sts;

    aff2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    aff2d_dp #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_beat (out_data)
    );

endmodule

[dv/testbench.sv]
// Testbench for the 2D affine concatenate/invert block.
// Scoreboard class predicts forward and inverse beats; depends on aff2d_pkg.
`timescale 1ns / 1ps
module testbench;
    import aff2d_pkg::*;

    localparam int FRAC = 16;
    localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;

    // Predicts the matrix pair for each accepted beat and checks results
    class affine_scoreboard;
        logic signed [31:0] cur_a, cur_b, cur_c, cur_d, cur_tx, cur_ty;
        aff2d_out_t         expected_beats[$];
        int                 mismatches;

        function new();
            mismatches = 0;
            load_identity();
        endfunction

        function void load_identity();
            cur_a = ONE_Q;
            cur_b = 0;
            cur_c = 0;
            cur_d = ONE_Q;
            cur_tx = 0;
            cur_ty = 0;
        endfunction

        // Clip a wide value to a 32-bit word and flag the clip
        function logic signed [31:0] clip32(logic signed [127:0] x, ref bit clipped);
            if (x > 128'sh7FFF_FFFF) begin
                clipped = 1;
                return 32'sh7FFF_FFFF;
            end
            if (x < -128'sh8000_0000) begin
                clipped = 1;
                return 32'sh8000_0000;
            end
            return x[31:0];
        endfunction

        // Exact product floored by the fraction bits
        function logic signed [127:0] mul_floor(logic signed [31:0] x, logic signed [31:0] y);
            logic signed [127:0] p;
            p = 128'(x) * 128'(y);
            return p >>> FRAC;
        endfunction

        function logic signed [127:0] wide(logic signed [31:0] x);
            return 128'(x);
        endfunction

        function void note_input(aff2d_in_t item);
            logic signed [31:0]  fa, fb, fc, fd, ftx, fty;
            logic signed [127:0] det;
            aff2d_out_t          fwd, inv;
            bit                  fclip, iclip, is_move;
            fclip = 0;
            iclip = 0;
            if (item.func) load_identity();
            fa = clip32(mul_floor(cur_a, item.in_a) + mul_floor(cur_c, item.in_b), fclip);
            fb = clip32(mul_floor(cur_b, item.in_a) + mul_floor(cur_d, item.in_b), fclip);
            fc = clip32(mul_floor(cur_a, item.in_c) + mul_floor(cur_c, item.in_d), fclip);
            fd = clip32(mul_floor(cur_b, item.in_c) + mul_floor(cur_d, item.in_d), fclip);
            ftx = clip32(wide(cur_tx) + mul_floor(cur_a, item.in_tx)
                         + mul_floor(cur_c, item.in_ty), fclip);
            fty = clip32(wide(cur_ty) + mul_floor(cur_b, item.in_tx)
                         + mul_floor(cur_d, item.in_ty), fclip);
            cur_a = fa; cur_b = fb; cur_c = fc; cur_d = fd; cur_tx = ftx; cur_ty = fty;
            is_move = (fa == ONE_Q && fb == 0 && fc == 0 && fd == ONE_Q);

            fwd = '{which: 1'b0, out_a: fa, out_b: fb, out_c: fc, out_d: fd,
                    out_tx: ftx, out_ty: fty, is_move: is_move, singular: 1'b0,
                    saturated: fclip, last: 1'b0};

            inv = '{which: 1'b1, out_a: ONE_Q, out_b: 0, out_c: 0, out_d: ONE_Q,
                    out_tx: 0, out_ty: 0, is_move: is_move, singular: 1'b0,
                    saturated: 1'b0, last: 1'b1};
            if (is_move) begin
                // pure move: negate translation, with clipping
                inv.out_tx = clip32(-wide(ftx), iclip);
                inv.out_ty = clip32(-wide(fty), iclip);
            end else begin
                det = (wide(fa) * wide(fd) - wide(fb) * wide(fc)) >>> FRAC;
                if (det == 0) begin
                    inv.singular = 1'b1;
                end else begin
                    inv.out_a = clip32((wide(fd) <<< FRAC) / det, iclip);
                    inv.out_b = clip32((-wide(fb) <<< FRAC) / det, iclip);
                    inv.out_c = clip32((-wide(fc) <<< FRAC) / det, iclip);
                    inv.out_d = clip32((wide(fa) <<< FRAC) / det, iclip);
                    inv.out_tx = clip32((wide(fc) * wide(fty) - wide(fd) * wide(ftx)) / det,
                                        iclip);
                    inv.out_ty = clip32((wide(fb) * wide(ftx) - wide(fa) * wide(fty)) / det,
                                        iclip);
                end
            end
            inv.saturated = iclip;
            expected_beats.push_back(fwd);
            expected_beats.push_back(inv);
        endfunction

        function void cmp(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                mismatches++;
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            end
        endfunction

        function void check_result(aff2d_out_t got);
            aff2d_out_t exp_b;
            if (expected_beats.size() == 0) begin
                mismatches++;
                $error("result beat with nothing expected");
                return;
            end
            exp_b = expected_beats.pop_front();
            cmp("which", exp_b.which, got.which);
            cmp("out_a", exp_b.out_a, got.out_a);
            cmp("out_b", exp_b.out_b, got.out_b);
            cmp("out_c", exp_b.out_c, got.out_c);
            cmp("out_d", exp_b.out_d, got.out_d);
            cmp("out_tx", exp_b.out_tx, got.out_tx);
            cmp("out_ty", exp_b.out_ty, got.out_ty);
            cmp("is_move", exp_b.is_move, got.is_move);
            cmp("singular", exp_b.singular, got.singular);
            cmp("saturated", exp_b.saturated, got.saturated);
            cmp("last", exp_b.last, got.last);
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    aff2d_in_t  in_data;
    logic       out_valid;
    logic       out_ready;
    aff2d_out_t out_data;

    affine_scoreboard sb = new();
    int burst_left;
    int stall_mode;
    int stall_cnt;

    affine_2d_concat_and_inverse u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Note accepted beats on both channels
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready) sb.note_input(in_data);
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    end

    // Stall the receiver on its own pattern: free runs, periodic and random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_mode <= 0;
            stall_cnt <= 0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt % 3000 == 2999) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= (stall_cnt % 7) < 4;
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Send one beat; insert a gap between bursts first
    task automatic send_item(aff2d_in_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_mat(bit func, int a, int b, int c, int d, int tx, int ty);
        aff2d_in_t item;
        item = '{func: func, in_a: a, in_b: b, in_c: c, in_d: d, in_tx: tx, in_ty: ty};
        send_item(item);
    endtask

    function automatic int near_q();
        return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endfunction

    function automatic aff2d_in_t random_item();
        aff2d_in_t item;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            // full-range noise
            item.func = 1'($urandom_range(0, 1));
            item.in_a = $urandom;
            item.in_b = $urandom;
            item.in_c = $urandom;
            item.in_d = $urandom;
            item.in_tx = $urandom;
            item.in_ty = $urandom;
        end
        else if (kind < 8)
        begin
            // well-formed transform with moderate scale
            item.func = ($urandom_range(0, 3) == 0);
            item.in_a = near_q();
            item.in_b = near_q();
            item.in_c = near_q();
            item.in_d = near_q();
            item.in_tx = $urandom;
            item.in_ty = $urandom;
            item.in_tx = item.in_tx >>> $urandom_range(0, 16);
            item.in_ty = item.in_ty >>> $urandom_range(0, 16);
        end
        else if (kind == 8)
        begin
            // pure translation
            item = '{func: 1'($urandom_range(0, 1)), in_a: ONE_Q, in_b: 0, in_c: 0,
                     in_d: ONE_Q, in_tx: $urandom, in_ty: $urandom};
        end
        else
        begin
            // rank-deficient: rows proportional
            item.func = 1'b1;
            item.in_a = near_q();
            item.in_b = near_q();
            item.in_c = item.in_a <<< 1;
            item.in_d = item.in_b <<< 1;
            item.in_tx = $urandom;
            item.in_ty = $urandom;
        end
        return item;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        burst_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, moves, extremes, singular and scaling cases
        send_mat(1'b0, ONE_Q, 0, 0, ONE_Q, 0, 0);
        send_mat(1'b0, ONE_Q, 0, 0, ONE_Q, 32'sh0003_8000, -32'sh0001_2000);
        send_mat(1'b1, ONE_Q, 0, 0, ONE_Q, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_mat(1'b0, ONE_Q, 0, 0, ONE_Q, 32'sh8000_0000, 32'sh8000_0000);
        send_mat(1'b1, 0, 0, 0, 0, 0, 0);
        send_mat(1'b1, 32'sh0002_0000, 0, 0, 32'sh0000_8000, 32'sh0001_0000, 32'sh0002_0000);
        send_mat(1'b0, 32'sh0000_0000, ONE_Q, -ONE_Q, 0, 32'sh0005_0000, 0);
        send_mat(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_mat(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh8000_0000);
        send_mat(1'b1, 32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, -1, 1);
        send_mat(1'b1, 1, 0, 0, 1, 0, 0);
        send_mat(1'b0, 32'sh0100_0000, 0, 0, 32'sh0100_0000, 32'sh0100_0000, 0);
        send_mat(1'b1, 32'sh0000_B505, 32'sh0000_B505, -32'sh0000_B505, 32'sh0000_B505,
                 32'sh0010_0000, -32'sh0010_0000);
        send_mat(1'b0, 32'sh0000_B505, -32'sh0000_B505, 32'sh0000_B505, 32'sh0000_B505,
                 0, 0);
        send_mat(1'b1, ONE_Q, 32'sh0002_0000, 32'sh0002_0000, 32'sh0004_0000, 7, -7);
        send_mat(1'b1, -1, -1, -1, -1, -1, -1);

        // Random part, with one full drain halfway
        for (int n = 0; n < 1000; n++)
        begin
            if (n == 500)
            begin
                in_valid <= 1'b0;
                burst_left = 0;
                while (sb.pending() != 0) @(posedge clk);
            end
            send_item(random_item());
        end
        in_valid <= 1'b0;

        // Drain and settle
        while (sb.pending() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Give up after a generous fixed time
    initial
    begin
        #60ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
